// File: design/bitmap_page_allocator_assert.svh
// assertion helpers shared by the allocator modules
// both expect signals named clock and reset in the enclosing module
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BPA_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/bpa_pkg.sv
`timescale 1ns / 1ps

package bpa_pkg;

   localparam int PAGE_FIELD_W   = 20;
   localparam int REGION_FIELD_W = 21;
   localparam int GRANT_FIELD_W  = 12;
   localparam int COUNT_FIELD_W  = 13;

   typedef enum logic [1:0] {
      OP_ADD_REGION     = 2'd0,
      OP_RESERVE_REGION = 2'd1,
      OP_ALLOC_PAGE     = 2'd2,
      OP_FREE_PAGE      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_NO_FREE      = 2'd1,
      ST_OUT_OF_RANGE = 2'd2,
      ST_ALREADY_FREE = 2'd3
   } status_type;

   typedef struct packed {
      op_type                    op;
      logic [PAGE_FIELD_W-1:0]   page_number;
      logic [REGION_FIELD_W-1:0] region_pages;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [GRANT_FIELD_W-1:0] granted_page;
      logic [COUNT_FIELD_W-1:0] free_count;
      logic [COUNT_FIELD_W-1:0] total_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       clear_en;
      logic       load;
      logic       raise_total;
      logic       rd_en;
      logic       modify;
      logic       advance;
      logic       respond;
      status_type status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic   clear_done;
      op_type op;
      logic   range_bad;
      logic   region_empty;
      logic   no_free;
      logic   last_word;
      logic   word_full;
      logic   bit_set;
   } sts_type;

endpackage

// File: design/bpa_ram.sv
`timescale 1ns / 1ps

module bpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rd_data_ff;

endmodule

// File: design/bpa_ctrl.sv
`timescale 1ns / 1ps
`include "bitmap_page_allocator_assert.svh"

module bpa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_valid,
   output bpa_pkg::cmd_type cmd,
   input  bpa_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_READ,
      S_MODIFY,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   bpa_pkg::status_type  status_ff, status_in;
   logic                 rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      cmd       = '0;
      cmd.status = status_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load  = 1'b1;
               status_in = bpa_pkg::ST_OK;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.op)
               bpa_pkg::OP_ADD_REGION, bpa_pkg::OP_RESERVE_REGION: begin
                  priority if (sts.range_bad) begin
                     status_in = bpa_pkg::ST_OUT_OF_RANGE;
                     state_in  = S_DONE;
                  end else if (sts.region_empty) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.raise_total = (sts.op == bpa_pkg::OP_ADD_REGION);
                     state_in        = S_READ;
                  end
               end
               bpa_pkg::OP_ALLOC_PAGE: begin
                  if (sts.no_free) begin
                     status_in = bpa_pkg::ST_NO_FREE;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end
               bpa_pkg::OP_FREE_PAGE: begin
                  if (sts.range_bad) begin
                     status_in = bpa_pkg::ST_OUT_OF_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_MODIFY;
         end
         S_MODIFY: begin
            unique case (sts.op)
               bpa_pkg::OP_ADD_REGION, bpa_pkg::OP_RESERVE_REGION: begin
                  cmd.modify = 1'b1;
                  if (sts.last_word) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.advance = 1'b1;
                     state_in    = S_READ;
                  end
               end
               bpa_pkg::OP_ALLOC_PAGE: begin
                  if (sts.word_full) begin
                     cmd.advance = 1'b1;
                     state_in    = S_READ;
                  end else begin
                     cmd.modify = 1'b1;
                     state_in   = S_DONE;
                  end
               end
               bpa_pkg::OP_FREE_PAGE: begin
                  if (sts.bit_set) begin
                     cmd.modify = 1'b1;
                  end else begin
                     status_in = bpa_pkg::ST_ALREADY_FREE;
                  end
                  state_in = S_DONE;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_DONE: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         status_ff    <= bpa_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= (state_ff == S_DONE);
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `BPA_ASSERT_NEXT(a_accept_decodes, start && !busy, state_ff == S_DECODE, "accepted word lost")
   `BPA_ASSERT_NEXT(a_single_strobe, rsp_valid_ff, !rsp_valid_ff, "result strobe repeated")
   `BPA_ASSERT_IMPLY(a_strobe_after_done, rsp_valid_ff, $past(state_ff) == S_DONE, "stray strobe")

endmodule

// File: design/bpa_datapath.sv
`timescale 1ns / 1ps
`include "bitmap_page_allocator_assert.svh"

module bpa_datapath #(
   parameter int NUM_PAGES = 4096,
   parameter int WORD_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  bpa_pkg::cmd_type cmd,
   input  bpa_pkg::req_type req_data,
   output bpa_pkg::sts_type sts,
   output bpa_pkg::rsp_type rsp_data
);

   localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int SPAN_W    = ADDR_W + BIT_W + 1;
   localparam int CNT_W     = $clog2(NUM_PAGES + 1);
   localparam int POP_W     = $clog2(WORD_BITS + 1);
   localparam int PAGE_FW   = bpa_pkg::PAGE_FIELD_W;
   localparam int REGION_FW = bpa_pkg::REGION_FIELD_W;
   localparam int SUM_W     = REGION_FW + 1;
   localparam int GNT_FW    = bpa_pkg::GRANT_FIELD_W;
   localparam int CNT_FW    = bpa_pkg::COUNT_FIELD_W;
   localparam logic [WORD_BITS-1:0] ONES    = '1;
   localparam logic [BIT_W-1:0]     TOP_BIT = BIT_W'(WORD_BITS - 1);

   // request held for the whole operation
   bpa_pkg::op_type          op_ff;
   logic [PAGE_FW-1:0]       page_ff;
   logic [REGION_FW-1:0]     pages_ff;
   logic [SPAN_W-1:0]        end_ff, end_in;
   logic [SPAN_W-1:0]        end_m1_ff;
   logic [SUM_W-1:0]         sum;

   logic [ADDR_W-1:0]        cursor_ff, cursor_in;
   logic [ADDR_W-1:0]        hint_ff, hint_in;
   logic [CNT_W-1:0]         free_ff, free_in;
   logic [CNT_W-1:0]         total_ff, total_in;
   logic [CNT_W-1:0]         end_cnt;
   logic [ADDR_W+BIT_W-1:0]  grant_ff, grant_in;
   bpa_pkg::rsp_type         rsp_ff;

   logic [ADDR_W-1:0]        first_word, last_word;
   logic [BIT_W-1:0]         first_bit, hi_bit, lo_sel, hi_sel, zero_idx;
   logic [WORD_BITS-1:0]     rd_word, mask, changed, new_word, free_hot, alloc_hot;
   logic [POP_W-1:0]         pop_count;
   logic                     word_full;
   logic                     ram_we;

   assign first_word = page_ff[BIT_W +: ADDR_W];
   assign first_bit  = page_ff[BIT_W-1:0];
   assign last_word  = end_m1_ff[BIT_W +: ADDR_W];
   assign hi_bit     = end_m1_ff[BIT_W-1:0];

   // clamp the region end to the bitmap size
   always_comb begin
      sum = SUM_W'(req_data.page_number) + SUM_W'(req_data.region_pages);
      if (sum > SUM_W'(NUM_PAGES)) begin
         end_in = SPAN_W'(NUM_PAGES);
      end else begin
         end_in = SPAN_W'(sum);
      end
   end

   // bits of the current word inside the region
   assign lo_sel = (cursor_ff == first_word) ? first_bit : '0;
   assign hi_sel = (cursor_ff == last_word) ? hi_bit : TOP_BIT;
   assign mask   = (ONES << lo_sel) & (ONES >> (TOP_BIT - hi_sel));

   assign word_full = &rd_word;

   // lowest clear bit
   always_comb begin
      zero_idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!rd_word[i]) begin
            zero_idx = BIT_W'(i);
         end
      end
   end

   assign free_hot  = WORD_BITS'(1) << first_bit;
   assign alloc_hot = WORD_BITS'(1) << zero_idx;

   always_comb begin
      changed  = '0;
      new_word = rd_word;
      unique case (op_ff)
         bpa_pkg::OP_ADD_REGION: begin
            changed  = rd_word & mask;
            new_word = rd_word & ~mask;
         end
         bpa_pkg::OP_RESERVE_REGION: begin
            changed  = ~rd_word & mask;
            new_word = rd_word | mask;
         end
         bpa_pkg::OP_ALLOC_PAGE: new_word = rd_word | alloc_hot;
         bpa_pkg::OP_FREE_PAGE:  new_word = rd_word & ~free_hot;
         default:                new_word = rd_word;
      endcase
   end

   always_comb begin
      pop_count = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         pop_count = pop_count + POP_W'(changed[i]);
      end
   end

   assign end_cnt = CNT_W'(end_ff);

   always_comb begin
      cursor_in = cursor_ff;
      hint_in   = hint_ff;
      free_in   = free_ff;
      total_in  = total_ff;
      grant_in  = grant_ff;
      if (cmd.load) begin
         grant_in = '0;
         if (req_data.op == bpa_pkg::OP_ALLOC_PAGE) begin
            cursor_in = hint_ff;
         end else begin
            cursor_in = req_data.page_number[BIT_W +: ADDR_W];
         end
      end
      if (cmd.clear_en || cmd.advance) begin
         cursor_in = cursor_ff + 1'b1;
      end
      if (cmd.raise_total) begin
         if (end_cnt > total_ff) begin
            total_in = end_cnt;
         end
         if (first_word < hint_ff) begin
            hint_in = first_word;
         end
      end
      if (cmd.modify) begin
         unique case (op_ff)
            bpa_pkg::OP_ADD_REGION:     free_in = free_ff + CNT_W'(pop_count);
            bpa_pkg::OP_RESERVE_REGION: free_in = free_ff - CNT_W'(pop_count);
            bpa_pkg::OP_ALLOC_PAGE: begin
               free_in  = free_ff - 1'b1;
               hint_in  = cursor_ff;
               grant_in = {cursor_ff, zero_idx};
            end
            bpa_pkg::OP_FREE_PAGE: begin
               free_in = free_ff + 1'b1;
               if (cursor_ff < hint_ff) begin
                  hint_in = cursor_ff;
               end
            end
            default: free_in = free_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         hint_ff   <= '0;
         free_ff   <= '0;
         total_ff  <= '0;
      end else begin
         cursor_ff <= cursor_in;
         hint_ff   <= hint_in;
         free_ff   <= free_in;
         total_ff  <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_data.op;
         page_ff  <= req_data.page_number;
         pages_ff <= req_data.region_pages;
         end_ff   <= end_in;
      end
      end_m1_ff <= end_ff - 1'b1;
      grant_ff  <= grant_in;
      if (cmd.respond) begin
         rsp_ff.status       <= cmd.status;
         rsp_ff.granted_page <= GNT_FW'(grant_ff);
         rsp_ff.free_count   <= CNT_FW'(free_ff);
         rsp_ff.total_count  <= CNT_FW'(total_ff);
      end
   end

   assign ram_we = cmd.clear_en | cmd.modify;

   bpa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (cursor_ff),
      .wdata (cmd.clear_en ? ONES : new_word),
      .re    (cmd.rd_en),
      .raddr (cursor_ff),
      .rdata (rd_word)
   );

   always_comb begin
      sts.clear_done   = (cursor_ff == ADDR_W'(MAP_WORDS - 1));
      sts.op           = op_ff;
      sts.range_bad    = ({1'b0, page_ff} >= (PAGE_FW + 1)'(NUM_PAGES));
      sts.region_empty = (pages_ff == '0);
      sts.no_free      = (free_ff == '0);
      sts.last_word    = (cursor_ff == last_word);
      sts.word_full    = word_full;
      sts.bit_set      = rd_word[first_bit];
   end

   assign rsp_data = rsp_ff;

   `BPA_ASSERT_IMPLY(a_free_bounded, 1'b1, free_ff <= CNT_W'(NUM_PAGES), "free count overflow")
   `BPA_ASSERT_IMPLY(a_write_in_map, ram_we, cursor_ff <= ADDR_W'(MAP_WORDS - 1), "write past map")
   `BPA_ASSERT_IMPLY(a_alloc_gap, cmd.modify && op_ff == bpa_pkg::OP_ALLOC_PAGE, !word_full, "alloc on full word")

endmodule

// File: design/bitmap_page_allocator.sv
`timescale 1ns / 1ps
// an accepted request is decoded, then each bitmap word it covers or scans is read and
// written back as needed; rejected or empty requests go straight to the result
// one request at a time, at most one read-modify-write of the bitmap memory per word; a new
// request is taken only after the result of the last one has been registered
// reset is synchronous; afterwards a clearing pass marks every page used, one bitmap word
// per cycle, busy high throughout; the receiver cannot stall

module bitmap_page_allocator #(
   parameter int NUM_PAGES = 4096,
   // bits per bitmap word, a power of two
   parameter int WORD_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   // request word, taken when start is high and busy is low
   input  logic             start,
   output logic             busy,
   input  bpa_pkg::req_type req_data,
   // result word, one per request, on rsp_data for one cycle under rsp_valid
   output logic             rsp_valid,
   output bpa_pkg::rsp_type rsp_data
);

   // control / status between the sequencer and the bitmap datapath
   bpa_pkg::cmd_type cmd;
   bpa_pkg::sts_type sts;

   // sequencer: clear sweep, decode, word walk, response strobe
   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath: request registers, bitmap memory, counters, lowest-free hint
   bpa_datapath #(
      .NUM_PAGES (NUM_PAGES),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
